// File: rtl/bair_pkg.sv
`default_nettype none
package bair_pkg;

    localparam int CAPACITY = 16;
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 5;
    localparam int CMP_W    = (FILL_W > POS_W) ? FILL_W : POS_W;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 5;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_INSERT = 3'd2,
        OP_REMOVE = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER
    } cell_sel_t;

    typedef struct packed {
        logic [2:0]               opcode;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] word_in;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] word_out;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
    } rsp_t;

    localparam logic signed [WORD_W-1:0] ERR_WORD = -WORD_W'(1);

endpackage
`default_nettype wire

// File: rtl/bounded_array_insert_remove.sv
`default_nettype none
// Ordered array held in a row of shifting cells, one entry per cell.
// The response is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle; a request stalls only while a response
// is held by a stalled consumer.
// Reset: the length clears to zero and no response is pending; cell contents
// are not reset.
module bounded_array_insert_remove (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 op_valid,
    output logic                op_stall,
    input  wire bair_pkg::req_t op,
    output logic                res_valid,
    input  wire                 res_stall,
    output bair_pkg::rsp_t      res
);
    import bair_pkg::*;

    logic [FILL_W-1:0]        fill_reg;
    logic [FILL_W-1:0]        fill_next;
    logic                     res_valid_reg;
    logic                     res_valid_next;
    rsp_t                     res_reg;
    rsp_t                     res_next;

    logic                     accept;
    logic [CMP_W-1:0]         fill_ext;
    logic [CMP_W-1:0]         pos_ext;
    logic [IDX_W-1:0]         rd_idx;
    logic signed [WORD_W-1:0] rd_word;
    logic                     do_push;
    logic                     do_insert;
    logic                     do_remove;

    cell_sel_t                sel [CAPACITY];
    logic signed [WORD_W-1:0] cell_word [CAPACITY];

    assign op_stall = res_valid_reg && res_stall;
    assign accept   = op_valid && !op_stall;
    assign fill_ext = CMP_W'(fill_reg);
    assign pos_ext  = CMP_W'(op.position);

    always_comb
    begin
        if (op.opcode == OP_POP)
        begin
            rd_idx = IDX_W'(fill_reg - FILL_W'(1));
        end
        else
        begin
            rd_idx = IDX_W'(op.position);
        end
    end

    assign rd_word = cell_word[rd_idx];

    always_comb
    begin
        fill_next        = fill_reg;
        do_push          = 1'b0;
        do_insert        = 1'b0;
        do_remove        = 1'b0;
        res_next         = res_reg;
        res_valid_next   = res_valid_reg && res_stall;
        if (accept)
        begin
            res_valid_next    = 1'b1;
            res_next.word_out = '0;
            res_next.status   = ST_OK;
            case (op.opcode)
                OP_PUSH:
                begin
                    if (fill_ext >= CMP_W'(CAPACITY))
                    begin
                        res_next.word_out = ERR_WORD;
                        res_next.status   = ST_FULL;
                    end
                    else
                    begin
                        do_push   = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                OP_POP:
                begin
                    if (fill_reg == '0)
                    begin
                        res_next.word_out = ERR_WORD;
                        res_next.status   = ST_EMPTY;
                    end
                    else
                    begin
                        fill_next         = fill_reg - FILL_W'(1);
                        res_next.word_out = rd_word;
                    end
                end
                OP_INSERT:
                begin
                    if (pos_ext > fill_ext)
                    begin
                        res_next.word_out = ERR_WORD;
                        res_next.status   = ST_RANGE;
                    end
                    else if (fill_ext >= CMP_W'(CAPACITY))
                    begin
                        res_next.word_out = ERR_WORD;
                        res_next.status   = ST_FULL;
                    end
                    else
                    begin
                        do_insert = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    if (pos_ext >= fill_ext)
                    begin
                        res_next.word_out = ERR_WORD;
                        res_next.status   = ST_RANGE;
                    end
                    else
                    begin
                        do_remove = 1'b1;
                        fill_next = fill_reg - FILL_W'(1);
                    end
                end
                OP_READ:
                begin
                    if (pos_ext >= fill_ext)
                    begin
                        res_next.word_out = ERR_WORD;
                        res_next.status   = ST_RANGE;
                    end
                    else
                    begin
                        res_next.word_out = rd_word;
                    end
                end
                default:
                begin
                    res_next.word_out = '0;
                end
            endcase
            res_next.count = COUNT_W'(fill_next);
        end
    end

    // per-cell shift control from position and fill compare
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel[i] = CELL_HOLD;
            if (do_push && (CMP_W'(i) == fill_ext))
            begin
                sel[i] = CELL_LOAD;
            end
            else if (do_insert && (CMP_W'(i) == pos_ext))
            begin
                sel[i] = CELL_LOAD;
            end
            else if (do_insert && (CMP_W'(i) > pos_ext))
            begin
                sel[i] = CELL_FROM_LOWER;
            end
            else if (do_remove && (CMP_W'(i) >= pos_ext) && (i < CAPACITY - 1))
            begin
                sel[i] = CELL_FROM_UPPER;
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [WORD_W-1:0] lower_w;
        logic signed [WORD_W-1:0] upper_w;
        if (g == 0)
        begin : g_bottom
            assign lower_w = '0;
        end
        else
        begin : g_lower
            assign lower_w = cell_word[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_top
            assign upper_w = cell_word[g];
        end
        else
        begin : g_upper
            assign upper_w = cell_word[g+1];
        end
        bair_cell u_cell (
            .clk        (clk),
            .sel        (sel[g]),
            .load_word  (op.word_in),
            .lower_word (lower_w),
            .upper_word (upper_w),
            .word       (cell_word[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire

// File: rtl/bair_cell.sv
`default_nettype none
module bair_cell (
    input  wire                                   clk,
    input  wire bair_pkg::cell_sel_t              sel,
    input  wire logic signed [bair_pkg::WORD_W-1:0] load_word,
    input  wire logic signed [bair_pkg::WORD_W-1:0] lower_word,
    input  wire logic signed [bair_pkg::WORD_W-1:0] upper_word,
    output logic signed [bair_pkg::WORD_W-1:0]      word
);
    import bair_pkg::*;

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;

    always_comb
    begin
        case (sel)
            CELL_HOLD:       word_next = word_reg;
            CELL_LOAD:       word_next = load_word;
            CELL_FROM_LOWER: word_next = lower_word;
            CELL_FROM_UPPER: word_next = upper_word;
            default:         word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule
`default_nettype wire
